// ----- design/contiguous_partition_allocator_defines.svh -----
// Assertion macros for the contiguous partition allocator.
// Depends on nothing. The asserting module must have clk and arst_n in scope.
`ifndef CONTIGUOUS_PARTITION_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PARTITION_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge out of reset.
`define CPA_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define CPA_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CPA_ASSERT_ALWAYS(label, expr, msg)
`define CPA_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

// ----- design/cpa_pkg.sv -----
// Shared constants for the contiguous partition allocator.
// Depends on nothing; used by the top level.
`default_nettype none

package cpa_pkg;

	// Size of the unit map and the widths that follow from it.
	localparam int MEM_UNITS   = 1024;
	localparam int JOB_ID_BITS = 8;
	localparam int ADDR_BITS   = $clog2(MEM_UNITS);
	localparam int CNT_BITS    = $clog2(MEM_UNITS + 1);

	// Fixed field widths of the request and result beats.
	localparam int ID_W    = 8;
	localparam int REQ_W   = 11;
	localparam int START_W = 10;
	localparam int COUNT_W = 11;

	// Request kinds.
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// Fit policies.
	localparam logic POLICY_FIRST = 1'b0;
	localparam logic POLICY_BEST  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NOFIT = 2'd1;
	localparam logic [1:0] STATUS_BAD   = 2'd2;

endpackage

`default_nettype wire

// ----- design/contiguous_partition_allocator.sv -----
// Contiguous partition allocator top level: unit map scan, claim and release.
// Depends on cpa_pkg, cpa_ram and contiguous_partition_allocator_defines.svh.
//
// A request beat is taken when start is high and busy is low. Every request gives
// exactly one result beat, shown for one cycle with done high; the receiver
// cannot stall it, so it must take it in that cycle. A request with id zero, an
// allocate of zero units, or one larger than the free units is answered without
// a scan. Any other request streams the unit map out of the owner RAM, one unit
// a cycle; a release streams the whole map. An allocate stops its scan when it
// has picked a run (first fit as soon as the run is long enough, best fit at an
// exact-size run or at the end of the map) and then writes the job id into the
// run one unit a cycle. After reset the block clears the owner RAM with busy
// high; fit_policy may be written then.
`default_nettype none
`include "contiguous_partition_allocator_defines.svh"

module contiguous_partition_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      fit_policy_we,
	input  wire logic                      fit_policy,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      kind,
	input  wire logic [cpa_pkg::ID_W-1:0]  job_id,
	input  wire logic [cpa_pkg::REQ_W-1:0] request_units,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [cpa_pkg::START_W-1:0]    start_unit,
	output logic [cpa_pkg::COUNT_W-1:0]    units_changed,
	output logic [cpa_pkg::COUNT_W-1:0]    free_units
);

	import cpa_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_CLAIM
	} state_t;

	state_t                 state_q;
	logic                   fit_policy_q;
	logic [CNT_BITS-1:0]    free_count_q;

	// Request held for the length of the operation.
	logic                   kind_q;
	logic [JOB_ID_BITS-1:0] id_q;
	logic [CNT_BITS-1:0]    size_q;

	// Scan read side and the unit index of the data coming back.
	logic [CNT_BITS-1:0]    addr_q;
	logic                   vld_s1;
	logic [ADDR_BITS-1:0]   idx_s1;

	// Run tracking.
	logic [CNT_BITS-1:0]    len_q;
	logic [ADDR_BITS-1:0]   run_start_q;
	logic                   found_q;
	logic [CNT_BITS-1:0]    best_len_q;
	logic [ADDR_BITS-1:0]   best_start_q;
	logic [CNT_BITS-1:0]    rel_cnt_q;

	// Claim sequencer.
	logic [ADDR_BITS-1:0]   claim_addr_q;
	logic [CNT_BITS-1:0]    claim_left_q;

	// Registered result beat.
	logic                   done_q;
	logic [1:0]             status_q;
	logic [START_W-1:0]     start_unit_q;
	logic [COUNT_W-1:0]     units_changed_q;
	logic [COUNT_W-1:0]     free_units_q;

	// RAM ports.
	logic                   mem_we;
	logic [ADDR_BITS-1:0]   mem_waddr;
	logic [JOB_ID_BITS-1:0] mem_wdata;
	logic [ADDR_BITS-1:0]   mem_raddr;
	logic [JOB_ID_BITS-1:0] mem_rdata;

	// Scan step terms.
	logic                   step;
	logic                   last;
	logic                   rd_free;
	logic                   rd_match;
	logic [CNT_BITS-1:0]    len_inc;
	logic [ADDR_BITS-1:0]   s_next;
	logic [CNT_BITS-1:0]    end_len;
	logic [ADDR_BITS-1:0]   end_start;
	logic                   end_ev;
	logic                   ff_hit;
	logic                   bf_exact;
	logic                   bf_better;
	logic                   issue;

	// Incoming request terms.
	logic [JOB_ID_BITS-1:0] in_id;
	logic [CNT_BITS-1:0]    in_size;
	logic                   in_bad;
	logic                   in_nofit;

	cpa_ram #(
		.WIDTH(JOB_ID_BITS),
		.DEPTH(MEM_UNITS)
	) u_owner_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Request decode at the accept edge.
	always_comb begin
		in_id    = job_id[JOB_ID_BITS-1:0];
		in_size  = request_units[CNT_BITS-1:0];
		in_bad   = (in_id == '0) || (kind == KIND_ALLOC && request_units == '0);
		in_nofit = (kind == KIND_ALLOC) &&
			((request_units > REQ_W'(MEM_UNITS)) || (in_size > free_count_q));
	end

	// One unit of the scan: run length, run start and the fit decisions.
	always_comb begin
		step      = (state_q == ST_SCAN) && vld_s1;
		last      = (idx_s1 == ADDR_BITS'(MEM_UNITS - 1));
		rd_free   = (mem_rdata == '0);
		rd_match  = (mem_rdata == id_q);
		len_inc   = len_q + CNT_BITS'(1);
		s_next    = (len_q == '0) ? idx_s1 : run_start_q;
		end_len   = rd_free ? len_inc : len_q;
		end_start = rd_free ? s_next : run_start_q;
		end_ev    = !rd_free || last;
		ff_hit    = rd_free && (len_inc == size_q);
		bf_exact  = end_ev && (end_len == size_q);
		bf_better = end_ev && (end_len > size_q) && (!found_q || end_len < best_len_q);
		issue     = (state_q == ST_SCAN) && (addr_q < CNT_BITS'(MEM_UNITS));
	end

	// RAM port selection. Scan reads run one unit ahead of release writes and
	// claim writes end before the next scan, so no entry is read and written at once.
	always_comb begin
		mem_raddr = addr_q[ADDR_BITS-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q[ADDR_BITS-1:0];
			end
			ST_SCAN: begin
				mem_we    = step && (kind_q == KIND_RELEASE) && rd_match;
				mem_waddr = idx_s1;
			end
			ST_CLAIM: begin
				mem_we    = 1'b1;
				mem_waddr = claim_addr_q;
				mem_wdata = id_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequencer, policy register, free count and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			fit_policy_q    <= POLICY_FIRST;
			free_count_q    <= CNT_BITS'(MEM_UNITS);
			addr_q          <= '0;
			vld_s1          <= 1'b0;
			done_q          <= 1'b0;
			found_q         <= 1'b0;
			claim_left_q    <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			idx_s1 <= addr_q[ADDR_BITS-1:0];
			if (issue) begin
				addr_q <= addr_q + CNT_BITS'(1);
			end
			if (fit_policy_we) begin
				fit_policy_q <= fit_policy;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + CNT_BITS'(1);
					if (addr_q == CNT_BITS'(MEM_UNITS - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						kind_q          <= kind;
						id_q            <= in_id;
						size_q          <= in_size;
						addr_q          <= '0;
						len_q           <= '0;
						run_start_q     <= '0;
						found_q         <= 1'b0;
						rel_cnt_q       <= '0;
						start_unit_q    <= '0;
						units_changed_q <= '0;
						free_units_q    <= COUNT_W'(free_count_q);
						if (in_bad) begin
							done_q   <= 1'b1;
							status_q <= STATUS_BAD;
						end else if (in_nofit) begin
							done_q   <= 1'b1;
							status_q <= STATUS_NOFIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (step) begin
						len_q       <= rd_free ? len_inc : '0;
						run_start_q <= s_next;
						if (kind_q == KIND_RELEASE) begin
							if (rd_match) begin
								rel_cnt_q <= rel_cnt_q + CNT_BITS'(1);
							end
							if (last) begin
								done_q          <= 1'b1;
								status_q        <= STATUS_OK;
								units_changed_q <= COUNT_W'(rel_cnt_q + CNT_BITS'(rd_match));
								free_units_q    <= COUNT_W'(free_count_q + rel_cnt_q +
									CNT_BITS'(rd_match));
								free_count_q    <= free_count_q + rel_cnt_q +
									CNT_BITS'(rd_match);
								state_q         <= ST_IDLE;
							end
						end else if (fit_policy_q == POLICY_FIRST) begin
							if (ff_hit) begin
								claim_addr_q <= s_next;
								start_unit_q <= START_W'(s_next);
								claim_left_q <= size_q;
								state_q      <= ST_CLAIM;
							end else if (last) begin
								done_q   <= 1'b1;
								status_q <= STATUS_NOFIT;
								state_q  <= ST_IDLE;
							end
						end else begin
							if (bf_exact) begin
								claim_addr_q <= end_start;
								start_unit_q <= START_W'(end_start);
								claim_left_q <= size_q;
								state_q      <= ST_CLAIM;
							end else begin
								if (bf_better) begin
									found_q      <= 1'b1;
									best_len_q   <= end_len;
									best_start_q <= end_start;
								end
								// End of map: take the best larger run, if any.
								if (last) begin
									if (bf_better || found_q) begin
										claim_addr_q <= bf_better ? end_start : best_start_q;
										start_unit_q <= START_W'(bf_better ? end_start :
											best_start_q);
										claim_left_q <= size_q;
										state_q      <= ST_CLAIM;
									end else begin
										done_q   <= 1'b1;
										status_q <= STATUS_NOFIT;
										state_q  <= ST_IDLE;
									end
								end
							end
						end
					end
				end
				ST_CLAIM: begin
					claim_addr_q <= claim_addr_q + ADDR_BITS'(1);
					claim_left_q <= claim_left_q - CNT_BITS'(1);
					if (claim_left_q == CNT_BITS'(1)) begin
						done_q          <= 1'b1;
						status_q        <= STATUS_OK;
						units_changed_q <= COUNT_W'(size_q);
						free_units_q    <= COUNT_W'(free_count_q - size_q);
						free_count_q    <= free_count_q - size_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Outputs.
	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign start_unit    = start_unit_q;
	assign units_changed = units_changed_q;
	assign free_units    = free_units_q;

	// The free count never exceeds the size of the map.
	`CPA_ASSERT_ALWAYS(a_free_bound, free_count_q <= CNT_BITS'(MEM_UNITS), "free count above map size")
	// Only a release writes the map during a scan.
	`CPA_ASSERT_IMPLY(a_scan_write, (state_q == ST_SCAN) && mem_we, kind_q == KIND_RELEASE, "scan write on allocate")
	// A claim always has units left to write.
	`CPA_ASSERT_IMPLY(a_claim_left, state_q == ST_CLAIM, claim_left_q != '0, "claim with no units left")
	// A failed request reports no start and no change.
	`CPA_ASSERT_IMPLY(a_fail_zero, done_q && (status_q != STATUS_OK), (start_unit_q == '0) && (units_changed_q == '0), "failed request with nonzero result")

endmodule

`default_nettype wire

// ----- design/cpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module cpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- verif/tb_contiguous_partition_allocator.sv -----
// Self-checking testbench for the contiguous partition allocator.
// Depends on cpa_pkg and the contiguous_partition_allocator top level.
// It runs a directed request table, then random request phases that alternate the fit policy.
`default_nettype none

module tb_contiguous_partition_allocator;
	import cpa_pkg::*;

	// One result beat: status, granted start unit, changed units, free units left.
	typedef struct packed {
		logic [1:0]         status;
		logic [START_W-1:0] first_unit;
		logic [COUNT_W-1:0] changed;
		logic [COUNT_W-1:0] free;
	} reply_t;

	// One directed request, with a typed reply where it is known at a glance.
	typedef struct packed {
		logic               kind;
		logic [ID_W-1:0]    id;
		logic [REQ_W-1:0]   units;
		logic               policy;
		logic               typed;
		reply_t             want;
	} step_t;

	localparam int RANDOM_ITEMS = 540;
	localparam int PHASES       = 4;

	logic               clk;
	logic               arst_n;
	logic               fit_policy_we;
	logic               fit_policy;
	logic               start;
	logic               busy;
	logic               kind;
	logic [ID_W-1:0]    job_id;
	logic [REQ_W-1:0]   request_units;
	logic               done;
	logic [1:0]         status;
	logic [START_W-1:0] start_unit;
	logic [COUNT_W-1:0] units_changed;
	logic [COUNT_W-1:0] free_units;

	// Shadow copy of the unit map, the free count and the policy.
	logic [ID_W-1:0] owner_map [MEM_UNITS];
	int              units_free;
	logic            policy_now;

	reply_t pending_replies [$];
	int     fault_count;
	bit     steady;

	// Directed requests: bad ids and sizes, oversize, whole-map runs, then a
	// fragmented map that exercises exact, smallest-larger and last-unit runs.
	step_t script [25] = '{
		'{KIND_ALLOC,   8'd0,   11'd5,    POLICY_FIRST, 1'b1, '{STATUS_BAD,   10'd0, 11'd0,    11'd1024}},
		'{KIND_ALLOC,   8'd1,   11'd0,    POLICY_FIRST, 1'b1, '{STATUS_BAD,   10'd0, 11'd0,    11'd1024}},
		'{KIND_RELEASE, 8'd0,   11'd0,    POLICY_FIRST, 1'b1, '{STATUS_BAD,   10'd0, 11'd0,    11'd1024}},
		'{KIND_ALLOC,   8'd1,   11'd1025, POLICY_FIRST, 1'b1, '{STATUS_NOFIT, 10'd0, 11'd0,    11'd1024}},
		'{KIND_ALLOC,   8'd2,   11'd2047, POLICY_FIRST, 1'b1, '{STATUS_NOFIT, 10'd0, 11'd0,    11'd1024}},
		'{KIND_RELEASE, 8'd7,   11'd0,    POLICY_FIRST, 1'b1, '{STATUS_OK,    10'd0, 11'd0,    11'd1024}},
		'{KIND_ALLOC,   8'd255, 11'd1024, POLICY_FIRST, 1'b1, '{STATUS_OK,    10'd0, 11'd1024, 11'd0}},
		'{KIND_ALLOC,   8'd3,   11'd1,    POLICY_FIRST, 1'b1, '{STATUS_NOFIT, 10'd0, 11'd0,    11'd0}},
		'{KIND_RELEASE, 8'd255, 11'd2047, POLICY_FIRST, 1'b1, '{STATUS_OK,    10'd0, 11'd1024, 11'd1024}},
		'{KIND_ALLOC,   8'd170, 11'd1024, POLICY_BEST,  1'b1, '{STATUS_OK,    10'd0, 11'd1024, 11'd0}},
		'{KIND_RELEASE, 8'd170, 11'd0,    POLICY_BEST,  1'b1, '{STATUS_OK,    10'd0, 11'd1024, 11'd1024}},
		'{KIND_ALLOC,   8'd1,   11'd10,   POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd2,   11'd20,   POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd3,   11'd5,    POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd4,   11'd30,   POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd5,   11'd3,    POLICY_BEST,  1'b0, '0},
		'{KIND_RELEASE, 8'd2,   11'd0,    POLICY_BEST,  1'b0, '0},
		'{KIND_RELEASE, 8'd4,   11'd0,    POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd6,   11'd30,   POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd7,   11'd15,   POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd8,   11'd956,  POLICY_BEST,  1'b0, '0},
		'{KIND_ALLOC,   8'd9,   11'd4,    POLICY_FIRST, 1'b0, '0},
		'{KIND_ALLOC,   8'd7,   11'd1,    POLICY_FIRST, 1'b0, '0},
		'{KIND_RELEASE, 8'd7,   11'd0,    POLICY_FIRST, 1'b0, '0},
		'{KIND_ALLOC,   8'd10,  11'd16,   POLICY_FIRST, 1'b0, '0}
	};

	contiguous_partition_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.fit_policy_we (fit_policy_we),
		.fit_policy    (fit_policy),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.job_id        (job_id),
		.request_units (request_units),
		.done          (done),
		.status        (status),
		.start_unit    (start_unit),
		.units_changed (units_changed),
		.free_units    (free_units)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("tb_contiguous_partition_allocator: FAIL");
		$finish;
	end

	// Applies one request to the shadow map and returns the reply it gives.
	function automatic reply_t apply_request(input logic k, input logic [ID_W-1:0] id,
			input logic [REQ_W-1:0] n);
		reply_t r;
		int     i;
		int     run_len;
		int     run_at;
		int     pick;
		int     pick_len;
		int     count;
		bit     found;
		bit     exact;
		r = '0;
		r.status = STATUS_OK;
		run_len = 0;
		run_at = 0;
		pick = 0;
		pick_len = 0;
		count = 0;
		found = 1'b0;
		exact = 1'b0;
		if (id == '0) begin
			r.status = STATUS_BAD;
		end else if (k == KIND_RELEASE) begin
			for (i = 0; i < MEM_UNITS; i++) begin
				if (owner_map[i] == id) begin
					owner_map[i] = '0;
					count++;
				end
			end
			units_free += count;
			r.changed = count[COUNT_W-1:0];
		end else if (n == '0) begin
			r.status = STATUS_BAD;
		end else if (int'(n) > units_free || int'(n) > MEM_UNITS) begin
			r.status = STATUS_NOFIT;
		end else begin
			if (policy_now == POLICY_FIRST) begin
				// First fit stops as soon as a free run is long enough.
				for (i = 0; i < MEM_UNITS && !found; i++) begin
					if (owner_map[i] == '0) begin
						if (run_len == 0)
							run_at = i;
						run_len++;
						if (run_len == int'(n)) begin
							found = 1'b1;
							pick = run_at;
						end
					end else begin
						run_len = 0;
					end
				end
			end else begin
				// Best fit closes each run at a used unit or past the last unit.
				for (i = 0; i <= MEM_UNITS && !exact; i++) begin
					if (i < MEM_UNITS && owner_map[i] == '0) begin
						if (run_len == 0)
							run_at = i;
						run_len++;
					end else begin
						if (run_len == int'(n)) begin
							found = 1'b1;
							exact = 1'b1;
							pick = run_at;
						end else if (run_len > int'(n) && (!found || run_len < pick_len)) begin
							found = 1'b1;
							pick = run_at;
							pick_len = run_len;
						end
						run_len = 0;
					end
				end
			end
			if (found) begin
				for (i = pick; i < pick + int'(n); i++)
					owner_map[i] = id;
				units_free -= int'(n);
				r.first_unit = pick[START_W-1:0];
				r.changed = n;
			end else begin
				r.status = STATUS_NOFIT;
			end
		end
		r.free = units_free[COUNT_W-1:0];
		return r;
	endfunction

	// Drives one request beat, after a random gap unless steady is set, and records its reply.
	task automatic send_request(input logic k, input logic [ID_W-1:0] id,
			input logic [REQ_W-1:0] n, input logic typed, input reply_t want);
		int     gap;
		reply_t r;
		gap = steady ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		job_id <= id;
		request_units <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = apply_request(k, id, n);
		pending_replies.push_back(typed ? want : r);
	endtask

	// Writes the policy once every outstanding reply has come back.
	task automatic set_policy(input logic p);
		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
		fit_policy_we <= 1'b1;
		fit_policy <= p;
		@(negedge clk);
		fit_policy_we <= 1'b0;
		policy_now = p;
	endtask

	// Compares each result beat with the oldest expected reply.
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && done) begin
			got = '{status, start_unit, units_changed, free_units};
			if (pending_replies.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result beat: status %0d start %0d changed %0d free %0d",
						got.status, got.first_unit, got.changed, got.free);
			end else begin
				want = pending_replies.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.status, want.first_unit, want.changed, want.free,
							got.status, got.first_unit, got.changed, got.free);
				end
			end
		end
	end

	initial begin
		int              idx;
		int              phase;
		int              pick_kind;
		logic            k;
		logic [ID_W-1:0] id;
		logic [REQ_W-1:0] n;
		fault_count = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		fit_policy_we = 1'b0;
		fit_policy = POLICY_FIRST;
		start = 1'b0;
		kind = KIND_ALLOC;
		job_id = '0;
		request_units = '0;
		for (idx = 0; idx < MEM_UNITS; idx++)
			owner_map[idx] = '0;
		units_free = MEM_UNITS;
		policy_now = POLICY_FIRST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The policy may be written while the map is still being cleared.
		set_policy(POLICY_FIRST);

		// Directed table.
		foreach (script[s]) begin
			if (script[s].policy != policy_now)
				set_policy(script[s].policy);
			send_request(script[s].kind, script[s].id, script[s].units,
				script[s].typed, script[s].want);
		end

		// Random phases alternate the policy; each phase starts on the other one.
		for (phase = 0; phase < PHASES; phase++) begin
			set_policy(phase[0] ? POLICY_FIRST : POLICY_BEST);
			for (idx = 0; idx < RANDOM_ITEMS / PHASES; idx++) begin
				if (idx % 30 == 0)
					steady = ($urandom_range(0, 3) == 0);
				pick_kind = $urandom_range(0, 99);
				// Ids mostly come from a small pool so that releases hit live jobs.
				id = ($urandom_range(0, 6) == 0) ? ID_W'($urandom_range(1, 255))
					: ID_W'($urandom_range(1, 24));
				k = KIND_ALLOC;
				if ($urandom_range(0, 19) < 16)
					n = REQ_W'($urandom_range(1, 40));
				else if ($urandom_range(0, 3) != 0)
					n = REQ_W'($urandom_range(41, 300));
				else
					n = REQ_W'($urandom_range(301, 2047));
				if (pick_kind >= 52 && pick_kind < 85) begin
					k = KIND_RELEASE;
					n = REQ_W'($urandom_range(0, 2047));
				end else if (pick_kind >= 85 && pick_kind < 90) begin
					k = logic'($urandom_range(0, 1));
					id = '0;
				end else if (pick_kind >= 90 && pick_kind < 95) begin
					n = '0;
				end else if (pick_kind >= 95) begin
					k = logic'($urandom_range(0, 1));
					id = ID_W'($urandom_range(0, 255));
					n = REQ_W'($urandom_range(0, 2047));
				end
				send_request(k, id, n, 1'b0, '0);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (MEM_UNITS + 64) @(posedge clk);
		if (fault_count == 0) begin
			$display("tb_contiguous_partition_allocator: PASS");
		end else begin
			$display("tb_contiguous_partition_allocator: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
